// ===== hdl/tbb_pkg.sv =====
package tbb_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int NUM_ROWS        = 3;
  localparam int ROW_WIDTH       = NUM_ROWS * COEF_WIDTH;
  localparam int SUM_WIDTH       = 34;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef logic [ROW_WIDTH-1:0]        row_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_Z = 2'd2;

  localparam row_t ROW_X_RESET = 48'h0000_0000_1000;
  localparam row_t ROW_Y_RESET = 48'h0000_1000_0000;
  localparam row_t ROW_Z_RESET = 48'h1000_0000_0000;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic last;
  } trk_ctl_t;

endpackage

// ===== hdl/tbb_dot.sv =====
module tbb_dot #(
  parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF
) (
  input  tbb_pkg::row_t                 coeffs,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  output tbb_pkg::sum_t                 sum
);
  import tbb_pkg::*;

  localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int EXT_W  = (ACC_W > SUM_WIDTH) ? ACC_W : SUM_WIDTH;

  logic signed [COEF_WIDTH-1:0] cx, cy, cz;
  logic signed [PROD_W-1:0]     px, py, pz;
  logic signed [ACC_W-1:0]      acc;
  logic signed [EXT_W-1:0]      acc_ext, max_ext, min_ext;

  assign cx = coeffs[COEF_WIDTH-1:0];
  assign cy = coeffs[2*COEF_WIDTH-1:COEF_WIDTH];
  assign cz = coeffs[3*COEF_WIDTH-1:2*COEF_WIDTH];

  assign px = cx * x;
  assign py = cy * y;
  assign pz = cz * z;

  assign acc     = ACC_W'(px) + ACC_W'(py) + ACC_W'(pz);
  assign acc_ext = EXT_W'(acc);
  assign max_ext = EXT_W'(SUM_MAX);
  assign min_ext = EXT_W'(SUM_MIN);

  // clamp only matters for wide coordinates
  always_comb begin
    if (acc_ext > max_ext) begin
      sum = SUM_MAX;
    end else if (acc_ext < min_ext) begin
      sum = SUM_MIN;
    end else begin
      sum = acc_ext[SUM_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/tbb_track.sv =====
module tbb_track (
  input  logic              clk,
  input  logic              rst,
  input  tbb_pkg::trk_ctl_t ctl,
  input  tbb_pkg::sum_t     sum_x,
  input  tbb_pkg::sum_t     sum_y,
  input  tbb_pkg::sum_t     sum_z,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tbb_pkg::sum_t     low_x,
  output tbb_pkg::sum_t     low_y,
  output tbb_pkg::sum_t     low_z,
  output tbb_pkg::sum_t     high_x,
  output tbb_pkg::sum_t     high_y,
  output tbb_pkg::sum_t     high_z
);
  import tbb_pkg::*;

  sum_t track_min_x, track_min_y, track_min_z;
  sum_t track_max_x, track_max_y, track_max_z;
  sum_t min_x_next, min_y_next, min_z_next;
  sum_t max_x_next, max_y_next, max_z_next;
  logic take;

  assign ready = !ctl.last || !out_valid || out_ready;
  assign take  = ctl.valid && ready;

  assign min_x_next = (sum_x < track_min_x) ? sum_x : track_min_x;
  assign min_y_next = (sum_y < track_min_y) ? sum_y : track_min_y;
  assign min_z_next = (sum_z < track_min_z) ? sum_z : track_min_z;
  assign max_x_next = (sum_x > track_max_x) ? sum_x : track_max_x;
  assign max_y_next = (sum_y > track_max_y) ? sum_y : track_max_y;
  assign max_z_next = (sum_z > track_max_z) ? sum_z : track_max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_min_x <= SUM_MAX;
      track_min_y <= SUM_MAX;
      track_min_z <= SUM_MAX;
      track_max_x <= SUM_MIN;
      track_max_y <= SUM_MIN;
      track_max_z <= SUM_MIN;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= (take && ctl.last) || (out_valid && !out_ready);
      if (take) begin
        if (ctl.last) begin
          track_min_x <= SUM_MAX;
          track_min_y <= SUM_MAX;
          track_min_z <= SUM_MAX;
          track_max_x <= SUM_MIN;
          track_max_y <= SUM_MIN;
          track_max_z <= SUM_MIN;
        end else begin
          track_min_x <= min_x_next;
          track_min_y <= min_y_next;
          track_min_z <= min_z_next;
          track_max_x <= max_x_next;
          track_max_y <= max_y_next;
          track_max_z <= max_z_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      low_x  <= min_x_next;
      low_y  <= min_y_next;
      low_z  <= min_z_next;
      high_x <= max_x_next;
      high_y <= max_y_next;
      high_z <= max_z_next;
    end
  end

endmodule

// ===== hdl/transformed_bounding_box.sv =====
// The box appears on the master side once the vertex marked last has passed the
// input register, the dot-product register and the result register.
// Throughput: one vertex per cycle; a held result stalls a last vertex and the input.
// Reset: coefficients return to the identity matrix, min/max trackers are cleared,
// and the pipeline and result register empty.
module transformed_bounding_box #(
  parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // coord_x, coord_y, coord_z, zero fill
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // low_x, low_y, low_z, high_x, high_y, high_z, zero fill
  output logic [((6*tbb_pkg::SUM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tbb_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  tbb_pkg::row_t                           cfg_data
);
  import tbb_pkg::*;

  localparam int OUT_W = ((6*SUM_WIDTH+7)/8)*8;

  row_t row_coeffs [NUM_ROWS];

  logic                          s0_valid;
  logic                          s0_last;
  logic signed [COORD_WIDTH-1:0] s0_x, s0_y, s0_z;
  logic                          s0_ready;

  sum_t dot_x, dot_y, dot_z;
  logic s1_valid;
  logic s1_last;
  sum_t s1_x, s1_y, s1_z;
  logic s1_ready;

  trk_ctl_t trk_ctl;
  logic     trk_ready;
  sum_t     low_x, low_y, low_z, high_x, high_y, high_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_coeffs[0] <= ROW_X_RESET;
      row_coeffs[1] <= ROW_Y_RESET;
      row_coeffs[2] <= ROW_Z_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_X: row_coeffs[0] <= cfg_data;
        CFG_ROW_Y: row_coeffs[1] <= cfg_data;
        CFG_ROW_Z: row_coeffs[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_ready      = !s1_valid || trk_ready;
  assign s0_ready      = !s0_valid || s1_ready;
  assign s_axis_tready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid <= s_axis_tvalid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s0_ready) begin
      s0_x    <= s_axis_tdata[COORD_WIDTH-1:0];
      s0_y    <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      s0_z    <= s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
      s0_last <= s_axis_tlast;
    end
    if (s0_valid && s1_ready) begin
      s1_x    <= dot_x;
      s1_y    <= dot_y;
      s1_z    <= dot_z;
      s1_last <= s0_last;
    end
  end

  tbb_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_x (
    .coeffs (row_coeffs[0]),
    .x      (s0_x),
    .y      (s0_y),
    .z      (s0_z),
    .sum    (dot_x)
  );

  tbb_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_y (
    .coeffs (row_coeffs[1]),
    .x      (s0_x),
    .y      (s0_y),
    .z      (s0_z),
    .sum    (dot_y)
  );

  tbb_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_z (
    .coeffs (row_coeffs[2]),
    .x      (s0_x),
    .y      (s0_y),
    .z      (s0_z),
    .sum    (dot_z)
  );

  assign trk_ctl.valid = s1_valid;
  assign trk_ctl.last  = s1_last;

  tbb_track u_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (trk_ctl),
    .sum_x     (s1_x),
    .sum_y     (s1_y),
    .sum_z     (s1_z),
    .ready     (trk_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .low_x     (low_x),
    .low_y     (low_y),
    .low_z     (low_z),
    .high_x    (high_x),
    .high_y    (high_y),
    .high_z    (high_z)
  );

  assign m_axis_tdata = OUT_W'({high_z, high_y, high_x, low_z, low_y, low_x});

endmodule

// ===== tb/sv/tb_transformed_bounding_box.sv =====
`timescale 1ns / 100ps

module tb_transformed_bounding_box;
  import tbb_pkg::*;

  localparam int TDATA_IN_W   = 48;
  localparam int TDATA_OUT_W  = 208;
  localparam int SETTLE_CYC   = 8;
  localparam int LONG_HOLD    = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [COEF_WIDTH-1:0] COEF_MIN  = 16'h8000;
  localparam logic [COEF_WIDTH-1:0] COEF_MAX  = 16'h7fff;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE  = 16'h1000;

  typedef struct packed {
    logic        last;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } vertex_t;

  typedef logic [6*SUM_WIDTH-1:0] box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  row_t                   cfg_data = '0;

  transformed_bounding_box uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  vertex_t vertex_pending[$];
  box_t    box_expected[$];
  vertex_t vertex_offered;

  row_t row_coef[NUM_ROWS] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
  sum_t lo_trk[NUM_ROWS];
  sum_t hi_trk[NUM_ROWS];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  bit pressure_phase  = 1'b0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  string box_field[6] = '{"low_x", "low_y", "low_z", "high_x", "high_y", "high_z"};

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic sum_t row_dot(row_t r, vertex_t v);
    longint s;
    s = longint'($signed(r[15:0]))  * longint'($signed(v.x))
      + longint'($signed(r[31:16])) * longint'($signed(v.y))
      + longint'($signed(r[47:32])) * longint'($signed(v.z));
    if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
    if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
    return sum_t'(s);
  endfunction

  task automatic clear_box();
    for (int a = 0; a < NUM_ROWS; a++) begin
      lo_trk[a] = SUM_MAX;
      hi_trk[a] = SUM_MIN;
    end
  endtask

  // Grow the box by one vertex; a last vertex closes the set.
  task automatic track_vertex(vertex_t v);
    sum_t t;
    for (int a = 0; a < NUM_ROWS; a++) begin
      t = row_dot(row_coef[a], v);
      if (t < lo_trk[a]) lo_trk[a] = t;
      if (t > hi_trk[a]) hi_trk[a] = t;
    end
    if (v.last) begin
      box_expected.insert(box_expected.size(), {hi_trk[2], hi_trk[1], hi_trk[0],
                                                lo_trk[2], lo_trk[1], lo_trk[0]});
      clear_box();
    end
  endtask

  // Vertex driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      clear_box();
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_vertex(vertex_offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (vertex_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          vertex_offered = vertex_pending.pop_front();
          s_axis_tdata  <= {vertex_offered.z, vertex_offered.y, vertex_offered.x};
          s_axis_tlast  <= vertex_offered.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Box receiver, with one long hold-off during the pressure phase
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (pressure_phase && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Box monitor
  always @(posedge clk) begin
    box_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (box_expected.size() == 0) begin
        $display("%0t: unexpected box transfer, actual %h", $time,
                 m_axis_tdata[6*SUM_WIDTH-1:0]);
        mismatch_count++;
      end else begin
        want = box_expected.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (m_axis_tdata[f*SUM_WIDTH +: SUM_WIDTH] !== want[f*SUM_WIDTH +: SUM_WIDTH]) begin
            $display("%0t: %s expected %h actual %h", $time, box_field[f],
                     want[f*SUM_WIDTH +: SUM_WIDTH], m_axis_tdata[f*SUM_WIDTH +: SUM_WIDTH]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.last = last;
    vertex_pending.insert(vertex_pending.size(), v);
  endtask

  task automatic write_row(logic [CFG_INDEX_WIDTH-1:0] idx, row_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_ROWS) row_coef[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  // Pause until every box is back and the pipeline has emptied.
  task automatic wait_quiet();
    do @(posedge clk);
    while (vertex_pending.size() != 0 || s_axis_tvalid || box_expected.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t pick_row();
    row_t r;
    for (int c = 0; c < NUM_ROWS; c++) begin
      case ($urandom_range(7))
        0: r[c*COEF_WIDTH +: COEF_WIDTH] = COEF_MIN;
        1: r[c*COEF_WIDTH +: COEF_WIDTH] = COEF_MAX;
        2: r[c*COEF_WIDTH +: COEF_WIDTH] = '0;
        3: r[c*COEF_WIDTH +: COEF_WIDTH] = COEF_ONE;
        default: r[c*COEF_WIDTH +: COEF_WIDTH] = 16'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic random_sets(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++)
        add_vertex(pick_coord(), pick_coord(), pick_coord(), k == len - 1);
      n += len;
    end
  endtask

  task automatic write_all_rows(row_t rx, row_t ry, row_t rz);
    write_row(CFG_ROW_X, rx);
    write_row(CFG_ROW_Y, ry);
    write_row(CFG_ROW_Z, rz);
  endtask

  initial begin
    @(negedge rst);

    // identity matrix: extremes, single and multi vertex sets
    add_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_vertex(16'hffff, 16'h0001, 16'h8000, 1'b0);
    add_vertex(16'h7fff, 16'h8000, 16'h1000, 1'b1);
    wait_quiet();

    write_all_rows({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
    add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
    add_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    add_vertex(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
    wait_quiet();

    write_all_rows({3{COEF_MAX}}, {COEF_MIN, COEF_MAX, COEF_MIN}, 48'hffff_ffff_ffff);
    add_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
    wait_quiet();

    // write in the middle of a set, plus a write to an unmapped index
    add_vertex(16'h1234, 16'hfedc, 16'h7fff, 1'b0);
    add_vertex(16'h8000, 16'h0042, 16'hc000, 1'b0);
    wait_quiet();
    write_row(CFG_ROW_X, pick_row());
    write_row(CFG_UNMAPPED, pick_row());
    add_vertex(16'h4000, 16'h8000, 16'h7fff, 1'b0);
    add_vertex(16'hffff, 16'h0000, 16'h0001, 1'b1);
    wait_quiet();

    // no idling
    write_all_rows(pick_row(), pick_row(), pick_row());
    random_sets(400);
    wait_quiet();

    sender_idle_pct = 47;
    write_all_rows({3{COEF_MIN}}, pick_row(), {3{COEF_MAX}});
    random_sets(400);
    wait_quiet();

    sender_idle_pct = 0;
    sink_stall_pct  = 47;
    write_all_rows(pick_row(), '0, pick_row());
    write_row(CFG_UNMAPPED, pick_row());
    random_sets(400);
    wait_quiet();

    sender_idle_pct = 10;
    sink_stall_pct  = 10;
    write_all_rows(pick_row(), pick_row(), pick_row());
    random_sets(400);
    wait_quiet();

    // long receiver hold-off while vertices keep coming
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    write_all_rows(pick_row(), pick_row(), pick_row());
    pressure_phase = 1'b1;
    random_sets(400);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tbb_pkg.sv
hdl/tbb_dot.sv
hdl/tbb_track.sv
hdl/transformed_bounding_box.sv
tb/sv/tb_transformed_bounding_box.sv
